>>> design/ptsd_pkg.sv
// ----------------------------------------------------------------------------
// ptsd_pkg
// Shared types, constants and latency helpers for the point to triangle
// squared distance unit.
// ----------------------------------------------------------------------------
package ptsd_pkg;

  // default configuration
  localparam int COORD_BITS_DEF      = 24;
  localparam int PARAM_FRAC_BITS_DEF = 24;

  // fixed output widths
  localparam int SQ_DIST_BITS = 52;
  localparam int REGION_BITS  = 3;

  // bits of the second operand consumed by one multiplier stage
  localparam int MUL_CHUNK = 16;

  // stages outside the wide multipliers and the dividers
  localparam int PIPE_FIXED_STAGES = 11;

  // voronoi regions of the triangle
  typedef enum logic [REGION_BITS-1:0] {
    RGN_FACE    = 3'd0,
    RGN_EDGE_BC = 3'd1,
    RGN_VTX_C   = 3'd2,
    RGN_EDGE_CA = 3'd3,
    RGN_VTX_A   = 3'd4,
    RGN_EDGE_AB = 3'd5,
    RGN_VTX_B   = 3'd6
  } region_t;

  localparam logic [REGION_BITS-1:0] REGION_MAX = RGN_VTX_B;

  // source of the t parameter
  typedef enum logic [1:0] {
    TSEL_ZERO,
    TSEL_DIV,
    TSEL_ONE_MINUS_S
  } tsel_t;

  // stages of one wide product: dot products are 2*cb+4 bits wide
  function automatic int ptsd_mul_lat(input int cb);
    int dw;
    dw = 2 * (cb + 1) + 2;
    return (dw + MUL_CHUNK - 1) / MUL_CHUNK;
  endfunction

  // start to result strobe, in clock cycles
  function automatic int ptsd_latency(input int cb, input int pf);
    return ptsd_mul_lat(cb) + pf + PIPE_FIXED_STAGES;
  endfunction

endpackage

>>> design/ptsd_mul.sv
// ----------------------------------------------------------------------------
// ptsd_mul
// Pipelined signed multiplier: one chunk of the second operand per stage,
// partial products accumulated in a running sum.
// ----------------------------------------------------------------------------
module ptsd_mul #(
  parameter int WA = 52,
  parameter int WB = 52,
  parameter int CH = 16
) (
  input  logic                    clk,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NCH = (WB + CH - 1) / CH;
  localparam int BX  = NCH * CH;
  localparam int PWD = WA + WB;

  logic signed [WA-1:0]  a_r   [NCH-1];
  logic signed [BX-1:0]  b_r   [NCH-1];
  logic signed [PWD-1:0] acc_r [NCH];

  for (genvar k = 0; k < NCH; k++) begin : g_st
    logic signed [WA-1:0]  a_in;
    logic signed [BX-1:0]  b_in;
    logic signed [PWD-1:0] acc_in;
    logic signed [CH:0]    dig;
    logic signed [WA+CH:0] pp;

    // operands from the ports or from the previous stage
    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BX'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    // top chunk carries the sign, lower chunks are unsigned
    if (k == NCH - 1) begin : g_top
      assign dig = {b_in[BX-1], b_in[k*CH +: CH]};
    end else begin : g_low
      assign dig = {1'b0, b_in[k*CH +: CH]};
    end

    assign pp = a_in * dig;

    always_ff @(posedge clk) begin
      acc_r[k] <= acc_in + (PWD'(pp) <<< (k * CH));
    end

    if (k < NCH - 1) begin : g_pass
      always_ff @(posedge clk) begin
        a_r[k] <= a_in;
        b_r[k] <= b_in;
      end
    end
  end

  assign p = acc_r[NCH-1];

endmodule

>>> design/ptsd_div.sv
// ----------------------------------------------------------------------------
// ptsd_div
// Pipelined restoring divider for a fraction num/den with num < den:
// one quotient bit per stage, QB stages.
// ----------------------------------------------------------------------------
module ptsd_div #(
  parameter int NW = 105,
  parameter int QB = 24
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic [QB-1:0] quo
);

  logic [NW-1:0] rem_r [QB-1];
  logic [NW-1:0] den_r [QB-1];
  logic [QB-1:0] quo_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_st
    logic [NW-1:0] rem_in;
    logic [NW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [NW:0]   trial;
    logic [NW+1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // shift in a zero and try to subtract the divisor
    assign trial = {rem_in, 1'b0};
    assign diff  = {1'b0, trial} - {2'b00, den_in};
    assign ge    = ~diff[NW+1];

    always_ff @(posedge clk) begin
      quo_r[k] <= {quo_in[QB-2:0], ge};
    end

    if (k < QB - 1) begin : g_pass
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? diff[NW-1:0] : trial[NW-1:0];
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

>>> design/point_triangle_sq_distance_unit.sv
// ----------------------------------------------------------------------------
// point_triangle_sq_distance_unit
// Exact squared distance from a query point to a 3D triangle, fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: a new item can be started in every cycle and busy stays
// low. The result strobe out_valid is carried down a valid shift register
// as deep as the data path. The depth is set by the two parameter dividers,
// which resolve one quotient bit per stage, by the wide product stages,
// which take 16 multiplier bits per stage, and by the fixed stages. The
// receiver cannot hold results off; each result is shown for exactly one
// cycle.
// ----------------------------------------------------------------------------
module point_triangle_sq_distance_unit import ptsd_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_vertex_a_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_a_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_a_z,
  input  logic signed [COORD_BITS-1:0] in_vertex_b_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_b_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_b_z,
  input  logic signed [COORD_BITS-1:0] in_vertex_c_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_c_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_c_z,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  output logic                         out_valid,
  output logic [SQ_DIST_BITS-1:0]      out_sq_distance,
  output logic [REGION_BITS-1:0]       out_region,
  output logic                         out_degenerate
);

  localparam int CB      = COORD_BITS;
  localparam int PF      = PARAM_FRAC_BITS;
  localparam int EW      = CB + 1;          // edge and offset vectors
  localparam int PW      = 2 * EW;          // one term of a dot product
  localparam int DW      = PW + 2;          // dot products a..e
  localparam int BW      = 2 * DW;          // wide products
  localparam int SW      = BW + 1;          // det, s, t and quotient operands
  localparam int QW      = PF + 1;          // parameters in [0,1]
  localparam int OFW     = EW + PF + 3;     // s*e0 + t*e1 before the shift
  localparam int DFW     = EW + 3;          // closest point minus query point
  localparam int SQW0    = 2 * DFW + 2;
  localparam int SQW     = (SQW0 > SQ_DIST_BITS) ? SQW0 : SQ_DIST_BITS + 1;
  localparam int MUL_LAT = ptsd_mul_lat(CB);
  localparam int LAT     = ptsd_latency(CB, PF);

  localparam logic [QW-1:0] PARAM_ONE = QW'(1) << PF;

  typedef struct packed {
    logic [2:0][CB-1:0] va;
    logic [2:0][CB-1:0] vp;
    logic [2:0][EW-1:0] e0;
    logic [2:0][EW-1:0] e1;
  } geom_t;

  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] c;
    logic [DW-1:0] d;
    logic [DW-1:0] e;
  } dots_t;

  typedef struct packed {
    region_t region;
    logic    s_use;
    tsel_t   tsel;
    logic    s_fix;
    logic    s_one;
    logic    t_fix;
    logic    t_one;
    logic    deg;
  } qctl_t;

  typedef struct packed {
    region_t region;
    logic    deg;
  } post_t;

  // never stalls
  assign busy = 1'b0;

  // valid bits, one per stage
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  // stage 1: edges and point offset
  logic [2:0][CB-1:0] pa, pb, pc, pq;
  geom_t              g1_nxt, g1_r;
  logic [2:0][EW-1:0] v0_nxt, v0_r;

  assign pa = {in_vertex_a_z, in_vertex_a_y, in_vertex_a_x};
  assign pb = {in_vertex_b_z, in_vertex_b_y, in_vertex_b_x};
  assign pc = {in_vertex_c_z, in_vertex_c_y, in_vertex_c_x};
  assign pq = {in_point_z, in_point_y, in_point_x};

  always_comb begin
    g1_nxt.va = pa;
    g1_nxt.vp = pq;
    for (int k = 0; k < 3; k++) begin
      g1_nxt.e0[k] = EW'($signed(pb[k])) - EW'($signed(pa[k]));
      g1_nxt.e1[k] = EW'($signed(pc[k])) - EW'($signed(pa[k]));
      v0_nxt[k]    = EW'($signed(pa[k])) - EW'($signed(pq[k]));
    end
  end

  always_ff @(posedge clk) begin
    g1_r <= g1_nxt;
    v0_r <= v0_nxt;
  end

  // stage 2: dot product terms
  logic signed [PW-1:0] ma_r [3];
  logic signed [PW-1:0] mb_r [3];
  logic signed [PW-1:0] mc_r [3];
  logic signed [PW-1:0] md_r [3];
  logic signed [PW-1:0] me_r [3];
  geom_t                g2_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ma_r[k] <= $signed(g1_r.e0[k]) * $signed(g1_r.e0[k]);
      mb_r[k] <= $signed(g1_r.e0[k]) * $signed(g1_r.e1[k]);
      mc_r[k] <= $signed(g1_r.e1[k]) * $signed(g1_r.e1[k]);
      md_r[k] <= $signed(g1_r.e0[k]) * $signed(v0_r[k]);
      me_r[k] <= $signed(g1_r.e1[k]) * $signed(v0_r[k]);
    end
    g2_r <= g1_r;
  end

  // stage 3: dot products
  dots_t dots3_r;
  geom_t g3_r;

  always_ff @(posedge clk) begin
    dots3_r.a <= DW'(ma_r[0]) + DW'(ma_r[1]) + DW'(ma_r[2]);
    dots3_r.b <= DW'(mb_r[0]) + DW'(mb_r[1]) + DW'(mb_r[2]);
    dots3_r.c <= DW'(mc_r[0]) + DW'(mc_r[1]) + DW'(mc_r[2]);
    dots3_r.d <= DW'(md_r[0]) + DW'(md_r[1]) + DW'(md_r[2]);
    dots3_r.e <= DW'(me_r[0]) + DW'(me_r[1]) + DW'(me_r[2]);
    g3_r      <= g2_r;
  end

  // wide products for det, s and t
  logic signed [BW-1:0] p_ac, p_bb, p_be, p_cd, p_bd, p_ae;

  ptsd_mul #(.WA(DW), .WB(DW), .CH(MUL_CHUNK)) u_mul_ac (
    .clk(clk), .a($signed(dots3_r.a)), .b($signed(dots3_r.c)), .p(p_ac));
  ptsd_mul #(.WA(DW), .WB(DW), .CH(MUL_CHUNK)) u_mul_bb (
    .clk(clk), .a($signed(dots3_r.b)), .b($signed(dots3_r.b)), .p(p_bb));
  ptsd_mul #(.WA(DW), .WB(DW), .CH(MUL_CHUNK)) u_mul_be (
    .clk(clk), .a($signed(dots3_r.b)), .b($signed(dots3_r.e)), .p(p_be));
  ptsd_mul #(.WA(DW), .WB(DW), .CH(MUL_CHUNK)) u_mul_cd (
    .clk(clk), .a($signed(dots3_r.c)), .b($signed(dots3_r.d)), .p(p_cd));
  ptsd_mul #(.WA(DW), .WB(DW), .CH(MUL_CHUNK)) u_mul_bd (
    .clk(clk), .a($signed(dots3_r.b)), .b($signed(dots3_r.d)), .p(p_bd));
  ptsd_mul #(.WA(DW), .WB(DW), .CH(MUL_CHUNK)) u_mul_ae (
    .clk(clk), .a($signed(dots3_r.a)), .b($signed(dots3_r.e)), .p(p_ae));

  // dot products and geometry ride along with the multipliers
  dots_t mdots_r [MUL_LAT];
  geom_t mg_r    [MUL_LAT];

  always_ff @(posedge clk) begin
    mdots_r[0] <= dots3_r;
    mg_r[0]    <= g3_r;
    for (int i = 1; i < MUL_LAT; i++) begin
      mdots_r[i] <= mdots_r[i-1];
      mg_r[i]    <= mg_r[i-1];
    end
  end

  // stage 5: det, s, t and the edge bc terms
  logic signed [DW-1:0] ma, mb, mc, md, me;
  logic signed [SW-1:0] det5_r, s5_r, t5_r;
  logic signed [DW+1:0] den5_r, n1_5_r;
  dots_t                dots5_r;
  geom_t                g5_r;

  assign ma = $signed(mdots_r[MUL_LAT-1].a);
  assign mb = $signed(mdots_r[MUL_LAT-1].b);
  assign mc = $signed(mdots_r[MUL_LAT-1].c);
  assign md = $signed(mdots_r[MUL_LAT-1].d);
  assign me = $signed(mdots_r[MUL_LAT-1].e);

  always_ff @(posedge clk) begin
    det5_r  <= SW'(p_ac) - SW'(p_bb);
    s5_r    <= SW'(p_be) - SW'(p_cd);
    t5_r    <= SW'(p_bd) - SW'(p_ae);
    den5_r  <= (DW+2)'(ma) - ((DW+2)'(mb) <<< 1) + (DW+2)'(mc);
    n1_5_r  <= ((DW+2)'(mc) + (DW+2)'(me)) - ((DW+2)'(mb) + (DW+2)'(md));
    dots5_r <= mdots_r[MUL_LAT-1];
    g5_r    <= mg_r[MUL_LAT-1];
  end

  // stage 6: region and quotient operands
  logic signed [DW-1:0] a5, b5, c5, d5, e5;
  logic signed [SW:0]   st_sum;
  logic signed [DW:0]   bd_sum, ce_sum, be_sum, ad_sum;
  logic signed [SW-1:0] neg_d, neg_e;
  logic                 in_wedge, bd_lt_ce, be_lt_ad;
  logic signed [SW-1:0] sn6_nxt, sd6_nxt, tn6_nxt, td6_nxt;
  logic signed [SW-1:0] sn6_r, sd6_r, tn6_r, td6_r;
  region_t              rgn6_nxt, rgn6_r;
  logic                 suse6_nxt, suse6_r;
  tsel_t                tsel6_nxt, tsel6_r;
  geom_t                g6_r;

  assign a5       = $signed(dots5_r.a);
  assign b5       = $signed(dots5_r.b);
  assign c5       = $signed(dots5_r.c);
  assign d5       = $signed(dots5_r.d);
  assign e5       = $signed(dots5_r.e);
  assign st_sum   = (SW+1)'(s5_r) + (SW+1)'(t5_r);
  assign in_wedge = st_sum < (SW+1)'(det5_r);
  assign bd_sum   = (DW+1)'(b5) + (DW+1)'(d5);
  assign ce_sum   = (DW+1)'(c5) + (DW+1)'(e5);
  assign be_sum   = (DW+1)'(b5) + (DW+1)'(e5);
  assign ad_sum   = (DW+1)'(a5) + (DW+1)'(d5);
  assign bd_lt_ce = bd_sum < ce_sum;
  assign be_lt_ad = be_sum < ad_sum;
  assign neg_d    = -SW'(d5);
  assign neg_e    = -SW'(e5);

  always_comb begin
    sn6_nxt   = '0;
    sd6_nxt   = '0;
    tn6_nxt   = '0;
    td6_nxt   = '0;
    suse6_nxt = 1'b0;
    tsel6_nxt = TSEL_ZERO;
    rgn6_nxt  = RGN_FACE;
    if (in_wedge) begin
      if (s5_r < 0) begin
        if (t5_r < 0) begin
          rgn6_nxt = RGN_VTX_A;
          if (d5 < 0) begin
            sn6_nxt   = neg_d;
            sd6_nxt   = SW'(a5);
            suse6_nxt = 1'b1;
          end else begin
            tn6_nxt   = neg_e;
            td6_nxt   = SW'(c5);
            tsel6_nxt = TSEL_DIV;
          end
        end else begin
          rgn6_nxt  = RGN_EDGE_CA;
          tn6_nxt   = neg_e;
          td6_nxt   = SW'(c5);
          tsel6_nxt = TSEL_DIV;
        end
      end else if (t5_r < 0) begin
        rgn6_nxt  = RGN_EDGE_AB;
        sn6_nxt   = neg_d;
        sd6_nxt   = SW'(a5);
        suse6_nxt = 1'b1;
      end else begin
        rgn6_nxt  = RGN_FACE;
        sn6_nxt   = s5_r;
        sd6_nxt   = det5_r;
        suse6_nxt = 1'b1;
        tn6_nxt   = t5_r;
        td6_nxt   = det5_r;
        tsel6_nxt = TSEL_DIV;
      end
    end else begin
      if (s5_r < 0) begin
        rgn6_nxt = RGN_VTX_C;
        if (bd_lt_ce) begin
          sn6_nxt   = SW'(n1_5_r);
          sd6_nxt   = SW'(den5_r);
          suse6_nxt = 1'b1;
          tsel6_nxt = TSEL_ONE_MINUS_S;
        end else begin
          tn6_nxt   = neg_e;
          td6_nxt   = SW'(c5);
          tsel6_nxt = TSEL_DIV;
        end
      end else if (t5_r < 0) begin
        rgn6_nxt = RGN_VTX_B;
        if (be_lt_ad) begin
          sn6_nxt   = SW'(n1_5_r);
          sd6_nxt   = SW'(den5_r);
          suse6_nxt = 1'b1;
          tsel6_nxt = TSEL_ONE_MINUS_S;
        end else begin
          // fall back along the edge t = 0
          sn6_nxt   = neg_d;
          sd6_nxt   = SW'(a5);
          suse6_nxt = 1'b1;
        end
      end else begin
        rgn6_nxt  = RGN_EDGE_BC;
        sn6_nxt   = SW'(n1_5_r);
        sd6_nxt   = SW'(den5_r);
        suse6_nxt = 1'b1;
        tsel6_nxt = TSEL_ONE_MINUS_S;
      end
    end
  end

  always_ff @(posedge clk) begin
    sn6_r   <= sn6_nxt;
    sd6_r   <= sd6_nxt;
    tn6_r   <= tn6_nxt;
    td6_r   <= td6_nxt;
    rgn6_r  <= rgn6_nxt;
    suse6_r <= suse6_nxt;
    tsel6_r <= tsel6_nxt;
    g6_r    <= g5_r;
  end

  // stage 7: zero divisor and clamp cases
  logic                 s_dz, s_np, s_ge, t_dz, t_np, t_ge;
  qctl_t                q7_nxt, q7_r;
  logic signed [SW-1:0] sn7_r, sd7_r, tn7_r, td7_r;
  geom_t                g7_r;

  assign s_dz = sd6_r == '0;
  assign s_np = sn6_r <= 0;
  assign s_ge = sn6_r >= sd6_r;
  assign t_dz = td6_r == '0;
  assign t_np = tn6_r <= 0;
  assign t_ge = tn6_r >= td6_r;

  always_comb begin
    q7_nxt.region = rgn6_r;
    q7_nxt.s_use  = suse6_r;
    q7_nxt.tsel   = tsel6_r;
    q7_nxt.s_fix  = s_dz | s_np | s_ge;
    q7_nxt.s_one  = ~s_dz & ~s_np & s_ge;
    q7_nxt.t_fix  = t_dz | t_np | t_ge;
    q7_nxt.t_one  = ~t_dz & ~t_np & t_ge;
    q7_nxt.deg    = (suse6_r & s_dz) | ((tsel6_r == TSEL_DIV) & t_dz);
  end

  always_ff @(posedge clk) begin
    q7_r  <= q7_nxt;
    sn7_r <= sn6_r;
    sd7_r <= sd6_r;
    tn7_r <= tn6_r;
    td7_r <= td6_r;
    g7_r  <= g6_r;
  end

  // fraction dividers
  logic [PF-1:0] q_s, q_t;

  ptsd_div #(.NW(SW), .QB(PF)) u_div_s (
    .clk(clk), .num(sn7_r), .den(sd7_r), .quo(q_s));
  ptsd_div #(.NW(SW), .QB(PF)) u_div_t (
    .clk(clk), .num(tn7_r), .den(td7_r), .quo(q_t));

  qctl_t dq_r [PF];
  geom_t dg_r [PF];

  always_ff @(posedge clk) begin
    dq_r[0] <= q7_r;
    dg_r[0] <= g7_r;
    for (int i = 1; i < PF; i++) begin
      dq_r[i] <= dq_r[i-1];
      dg_r[i] <= dg_r[i-1];
    end
  end

  // stage 8: final s and t
  qctl_t         qc;
  logic [QW-1:0] s8_nxt, t8_nxt, s8_r, t8_r;
  post_t         p8_r;
  geom_t         g8_r;

  assign qc = dq_r[PF-1];

  always_comb begin
    if (!qc.s_use) begin
      s8_nxt = '0;
    end else if (qc.s_fix) begin
      s8_nxt = qc.s_one ? PARAM_ONE : '0;
    end else begin
      s8_nxt = {1'b0, q_s};
    end
    case (qc.tsel)
      TSEL_DIV: begin
        if (qc.t_fix) begin
          t8_nxt = qc.t_one ? PARAM_ONE : '0;
        end else begin
          t8_nxt = {1'b0, q_t};
        end
      end
      TSEL_ONE_MINUS_S: t8_nxt = PARAM_ONE - s8_nxt;
      default:          t8_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    s8_r        <= s8_nxt;
    t8_r        <= t8_nxt;
    p8_r.region <= qc.region;
    p8_r.deg    <= qc.deg;
    g8_r        <= dg_r[PF-1];
  end

  // stage 9: parameter times edge
  logic signed [EW+PF+1:0] ps9_r [3];
  logic signed [EW+PF+1:0] pt9_r [3];
  post_t                   p9_r;
  geom_t                   g9_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ps9_r[k] <= $signed({1'b0, s8_r}) * $signed(g8_r.e0[k]);
      pt9_r[k] <= $signed({1'b0, t8_r}) * $signed(g8_r.e1[k]);
    end
    p9_r <= p8_r;
    g9_r <= g8_r;
  end

  // stage 10: closest point minus query point
  logic signed [OFW-1:0] off_sum [3];
  logic signed [DFW-1:0] df10_r  [3];
  post_t                 p10_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      off_sum[k] = OFW'(ps9_r[k]) + OFW'(pt9_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      df10_r[k] <= DFW'($signed(g9_r.va[k])) + DFW'(off_sum[k] >>> PF)
                 - DFW'($signed(g9_r.vp[k]));
    end
    p10_r <= p9_r;
  end

  // stage 11: squares
  logic signed [2*DFW-1:0] sq11_r [3];
  post_t                   p11_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq11_r[k] <= df10_r[k] * df10_r[k];
    end
    p11_r <= p10_r;
  end

  // stage 12: sum and saturation
  logic [SQW-1:0]          sq_sum;
  logic [SQ_DIST_BITS-1:0] out_sq_r;
  post_t                   p12_r;

  assign sq_sum = SQW'(unsigned'(sq11_r[0])) + SQW'(unsigned'(sq11_r[1]))
                + SQW'(unsigned'(sq11_r[2]));

  always_ff @(posedge clk) begin
    if (sq_sum[SQW-1:SQ_DIST_BITS] != '0) begin
      out_sq_r <= '1;
    end else begin
      out_sq_r <= sq_sum[SQ_DIST_BITS-1:0];
    end
    p12_r <= p11_r;
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_sq_distance = out_sq_r;
  assign out_region      = p12_r.region;
  assign out_degenerate  = p12_r.deg;

endmodule

>>> design/ptsd_chk.sv
// ----------------------------------------------------------------------------
// ptsd_chk
// Port level checks of the distance unit: fixed latency, reset, region code.
// ----------------------------------------------------------------------------
module ptsd_chk import ptsd_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic [REGION_BITS-1:0] out_region
);

  localparam int LAT = ptsd_latency(COORD_BITS, PARAM_FRAC_BITS);

  // every accepted item yields a result after the pipeline depth
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted item produced no result");

  // no result without an item accepted that many cycles earlier
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

  // reset flushes the pipeline
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // only seven regions exist
  a_rgn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_region <= REGION_MAX))
    else $error("region code out of range");

endmodule

bind point_triangle_sq_distance_unit ptsd_chk #(
  .COORD_BITS(COORD_BITS),
  .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
) u_ptsd_chk (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid),
  .out_region(out_region)
);
